// ===== rtl/sphere_contact_query_engine_macros.svh =====
// Assertion macros shared by the contact query engine.
`ifndef SPHERE_CONTACT_QUERY_ENGINE_MACROS_SVH
`define SPHERE_CONTACT_QUERY_ENGINE_MACROS_SVH

// Whenever the condition holds, the consequence holds in the same cycle.
`define SCQE_ASSERT_SAME(label, clk, rst_n, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error("scqe: same-cycle check failed");

// Whenever the condition holds, the consequence holds in the next cycle.
`define SCQE_ASSERT_NEXT(label, clk, rst_n, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error("scqe: next-cycle check failed");

`endif

// ===== rtl/scqe_pkg.sv =====
package scqe_pkg;

    // Default sizes of the sphere table.
    localparam int ENTRIES_DEF    = 64;
    localparam int COORD_BITS_DEF = 20;

    // Field widths of the words on the two channels.
    localparam int CMD_W    = 2;
    localparam int SLOT_W   = 6;
    localparam int FIELD_W  = 20;
    localparam int RADIUS_W = 18;
    localparam int TAG_W    = 4;
    localparam int MODE_W   = 2;
    localparam int RSUM_W   = RADIUS_W + 1;

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_WRITE  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd2;

    // Query modes.
    localparam logic [MODE_W-1:0] MODE_OVERLAP = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ENTER   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_EXIT    = 2'd2;
    localparam logic [MODE_W-1:0] MODE_ALL     = 2'd3;

    // A tag filter of this value passes every entry.
    localparam logic [TAG_W-1:0] TAG_ANY = 4'd0;

    typedef struct packed {
        logic [CMD_W-1:0]           command;
        logic [SLOT_W-1:0]          slot;
        logic signed [FIELD_W-1:0]  pos_x;
        logic signed [FIELD_W-1:0]  pos_y;
        logic signed [FIELD_W-1:0]  pos_z;
        logic signed [FIELD_W-1:0]  prev_x;
        logic signed [FIELD_W-1:0]  prev_y;
        logic signed [FIELD_W-1:0]  prev_z;
        logic [RADIUS_W-1:0]        radius;
        logic [TAG_W-1:0]           tag;
        logic [MODE_W-1:0]          mode;
    } t_req;

    typedef struct packed {
        logic              hit;
        logic [SLOT_W-1:0] hit_slot;
        logic              last;
    } t_rsp;

endpackage

// ===== rtl/scqe_if.sv =====
// Command channel into the engine.
interface scqe_req_if;
    import scqe_pkg::*;

    logic valid;
    logic ready;
    t_req data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// Result channel out of the engine.
interface scqe_rsp_if;
    import scqe_pkg::*;

    logic valid;
    logic ready;
    t_rsp data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/scqe_dist_unit.sv =====
module scqe_dist_unit #(
    parameter int COORD_BITS = scqe_pkg::COORD_BITS_DEF,
    localparam int OPW   = (COORD_BITS > scqe_pkg::RSUM_W) ? COORD_BITS : scqe_pkg::RSUM_W,
    localparam int ACC_W = 2 * OPW + 2
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    input  logic signed [COORD_BITS-1:0]       i_q_now    [3],
    input  logic signed [COORD_BITS-1:0]       i_q_before [3],
    input  logic signed [COORD_BITS-1:0]       i_e_now    [3],
    input  logic signed [COORD_BITS-1:0]       i_e_before [3],
    input  logic [scqe_pkg::RADIUS_W-1:0]      i_q_radius,
    input  logic [scqe_pkg::RADIUS_W-1:0]      i_e_radius,
    output logic                               o_done,
    output logic [ACC_W-1:0]                   o_dn,
    output logic [ACC_W-1:0]                   o_db,
    output logic [ACC_W-1:0]                   o_r2
);
    import scqe_pkg::*;

    localparam int PROD_W = 2 * OPW;
    localparam int STEP_W = 4;

    // Step schedule: seven operands, each squared one step later and
    // summed one step after that.
    localparam logic [STEP_W-1:0] ST_NOW_X  = 4'd0;
    localparam logic [STEP_W-1:0] ST_NOW_Y  = 4'd1;
    localparam logic [STEP_W-1:0] ST_NOW_Z  = 4'd2;
    localparam logic [STEP_W-1:0] ST_BEF_X  = 4'd3;
    localparam logic [STEP_W-1:0] ST_BEF_Y  = 4'd4;
    localparam logic [STEP_W-1:0] ST_BEF_Z  = 4'd5;
    localparam logic [STEP_W-1:0] ST_RSUM   = 4'd6;
    localparam logic [STEP_W-1:0] ST_SQ_END = 4'd7;
    localparam logic [STEP_W-1:0] ST_LAST   = 4'd8;

    logic                 r_busy;
    logic                 r_done;
    logic [STEP_W-1:0]    r_step;
    logic [OPW-1:0]       r_opnd;
    logic [PROD_W-1:0]    r_prod;
    logic [ACC_W-1:0]     r_acc;
    logic [ACC_W-1:0]     r_dn;
    logic [ACC_W-1:0]     r_db;
    logic [ACC_W-1:0]     r_r2;
    logic [OPW-1:0]       opnd_sel;
    logic [PROD_W-1:0]    sq;
    logic [ACC_W-1:0]     prod_ext;
    logic [RSUM_W-1:0]    rsum;

    // Magnitude of the difference of two coordinates.
    function automatic logic [OPW-1:0] abs_diff(input logic signed [COORD_BITS-1:0] a,
                                                input logic signed [COORD_BITS-1:0] b);
        logic [COORD_BITS:0] d;
        logic [COORD_BITS:0] m;
        d = {a[COORD_BITS-1], a} - {b[COORD_BITS-1], b};
        m = d[COORD_BITS] ? (~d + 1'b1) : d;
        return OPW'(m[COORD_BITS-1:0]);
    endfunction

    assign rsum = RSUM_W'(i_q_radius) + RSUM_W'(i_e_radius);

    // Operand for the current step.
    always_comb begin
        case (r_step)
            ST_NOW_X: opnd_sel = abs_diff(i_e_now[0], i_q_now[0]);
            ST_NOW_Y: opnd_sel = abs_diff(i_e_now[1], i_q_now[1]);
            ST_NOW_Z: opnd_sel = abs_diff(i_e_now[2], i_q_now[2]);
            ST_BEF_X: opnd_sel = abs_diff(i_e_before[0], i_q_before[0]);
            ST_BEF_Y: opnd_sel = abs_diff(i_e_before[1], i_q_before[1]);
            ST_BEF_Z: opnd_sel = abs_diff(i_e_before[2], i_q_before[2]);
            default:  opnd_sel = OPW'(rsum);
        endcase
    end

    // The one squarer of the unit.
    assign sq       = r_opnd * r_opnd;
    assign prod_ext = ACC_W'(r_prod);

    // Step counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= r_busy && (r_step == ST_LAST);
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                if (r_step == ST_LAST) begin
                    r_busy <= 1'b0;
                end else begin
                    r_step <= r_step + 1'b1;
                end
            end
        end
    end

    // Operand, square and sum stages.
    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            if (r_step <= ST_RSUM) begin
                r_opnd <= opnd_sel;
            end
            if (r_step >= ST_NOW_Y && r_step <= ST_SQ_END) begin
                r_prod <= sq;
            end
            case (r_step)
                ST_NOW_Z: r_acc <= prod_ext;
                ST_BEF_X: r_acc <= r_acc + prod_ext;
                ST_BEF_Y: r_dn  <= r_acc + prod_ext;
                ST_BEF_Z: r_acc <= prod_ext;
                ST_RSUM:  r_acc <= r_acc + prod_ext;
                ST_SQ_END: r_db <= r_acc + prod_ext;
                ST_LAST:  r_r2  <= prod_ext;
                default:  r_acc <= r_acc;
            endcase
        end
    end

    assign o_done = r_done;
    assign o_dn   = r_dn;
    assign o_db   = r_db;
    assign o_r2   = r_r2;

endmodule

// ===== rtl/sphere_contact_query_engine.sv =====
// Write and remove words are taken only while idle and give no result.
// A query scans slots in ascending order: an empty or own slot is skipped, a slot whose tag
// fails the filter is read but not compared, and any other slot is compared.
// The time taken per compared slot is set by the one squarer, which does seven squares each.
// Reset clears the valid bits at once; table contents stay undefined and are never read
// before a write, so there is no clearing pass.
`include "sphere_contact_query_engine_macros.svh"

module sphere_contact_query_engine #(
    parameter int ENTRIES    = scqe_pkg::ENTRIES_DEF,
    parameter int COORD_BITS = scqe_pkg::COORD_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    scqe_req_if.sink    i_req,
    scqe_rsp_if.source  o_rsp
);
    import scqe_pkg::*;

    localparam int IDX_W  = $clog2(ENTRIES);
    localparam int OPW    = (COORD_BITS > RSUM_W) ? COORD_BITS : RSUM_W;
    localparam int ACC_W  = 2 * OPW + 2;
    localparam int BEF_LSB = 3 * COORD_BITS;
    localparam int RAD_LSB = 6 * COORD_BITS;
    localparam int TAG_LSB = RAD_LSB + RADIUS_W;
    localparam int MEM_W   = TAG_LSB + TAG_W;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_ADDR = 6'b000010,
        S_LOAD = 6'b000100,
        S_CALC = 6'b001000,
        S_EVAL = 6'b010000,
        S_FIN  = 6'b100000
    } t_state;

    t_state                      r_state, n_state;
    logic [IDX_W-1:0]            r_idx, n_idx;
    logic                        r_pend_valid, n_pend_valid;
    logic [IDX_W-1:0]            r_pend_slot, n_pend_slot;
    logic                        r_out_valid, n_out_valid;
    t_rsp                        r_out, n_out;
    logic [ENTRIES-1:0]          r_valid;

    logic [SLOT_W-1:0]           r_own;
    logic signed [COORD_BITS-1:0] r_q_now    [3];
    logic signed [COORD_BITS-1:0] r_q_before [3];
    logic [RADIUS_W-1:0]         r_q_radius;
    logic [TAG_W-1:0]            r_q_tag;
    logic [MODE_W-1:0]           r_q_mode;

    logic [MEM_W-1:0]            mem [ENTRIES];
    logic [MEM_W-1:0]            r_rd;
    logic [MEM_W-1:0]            wr_word;

    logic signed [COORD_BITS-1:0] e_now    [3];
    logic signed [COORD_BITS-1:0] e_before [3];
    logic [RADIUS_W-1:0]         e_radius;
    logic [TAG_W-1:0]            e_tag;

    logic                        accept;
    logic                        slot_ok;
    logic                        cand;
    logic                        tag_ok;
    logic                        mem_re;
    logic                        dist_start;
    logic                        out_free;
    logic                        match;
    logic                        dist_done;
    logic [ACC_W-1:0]            dn, db, r2;

    assign i_req.ready = (r_state == S_IDLE);
    assign accept      = i_req.valid && (r_state == S_IDLE);
    assign slot_ok     = {1'b0, i_req.data.slot} < (SLOT_W + 1)'(ENTRIES);
    assign out_free    = !r_out_valid || o_rsp.ready;

    // Fields of the entry that was read.
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            e_now[k]    = r_rd[k * COORD_BITS +: COORD_BITS];
            e_before[k] = r_rd[BEF_LSB + k * COORD_BITS +: COORD_BITS];
        end
    end
    assign e_radius = r_rd[RAD_LSB +: RADIUS_W];
    assign e_tag    = r_rd[TAG_LSB +: TAG_W];

    assign cand   = r_valid[r_idx] && (SLOT_W'(r_idx) != r_own);
    assign tag_ok = (r_q_tag == TAG_ANY) || (e_tag == r_q_tag);
    assign mem_re = (r_state == S_ADDR) && cand;
    assign dist_start = (r_state == S_LOAD) && tag_ok;

    assign wr_word = {i_req.data.tag, i_req.data.radius,
                      i_req.data.prev_z[COORD_BITS-1:0], i_req.data.prev_y[COORD_BITS-1:0],
                      i_req.data.prev_x[COORD_BITS-1:0], i_req.data.pos_z[COORD_BITS-1:0],
                      i_req.data.pos_y[COORD_BITS-1:0], i_req.data.pos_x[COORD_BITS-1:0]};

    // Sphere table.
    always_ff @(posedge i_clk) begin
        if (accept && i_req.data.command == CMD_WRITE && slot_ok) begin
            mem[i_req.data.slot[IDX_W-1:0]] <= wr_word;
        end
        if (mem_re) begin
            r_rd <= mem[r_idx];
        end
    end

    // Valid bits, one per slot.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (accept && slot_ok) begin
            if (i_req.data.command == CMD_WRITE) begin
                r_valid[i_req.data.slot[IDX_W-1:0]] <= 1'b1;
            end else if (i_req.data.command == CMD_REMOVE) begin
                r_valid[i_req.data.slot[IDX_W-1:0]] <= 1'b0;
            end
        end
    end

    // Query word held for the whole scan.
    always_ff @(posedge i_clk) begin
        if (accept && i_req.data.command == CMD_QUERY) begin
            r_own         <= i_req.data.slot;
            r_q_now[0]    <= i_req.data.pos_x[COORD_BITS-1:0];
            r_q_now[1]    <= i_req.data.pos_y[COORD_BITS-1:0];
            r_q_now[2]    <= i_req.data.pos_z[COORD_BITS-1:0];
            r_q_before[0] <= i_req.data.prev_x[COORD_BITS-1:0];
            r_q_before[1] <= i_req.data.prev_y[COORD_BITS-1:0];
            r_q_before[2] <= i_req.data.prev_z[COORD_BITS-1:0];
            r_q_radius    <= i_req.data.radius;
            r_q_tag       <= i_req.data.tag;
            r_q_mode      <= i_req.data.mode;
        end
    end

    scqe_dist_unit #(
        .COORD_BITS (COORD_BITS)
    ) u_dist (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (dist_start),
        .i_q_now    (r_q_now),
        .i_q_before (r_q_before),
        .i_e_now    (e_now),
        .i_e_before (e_before),
        .i_q_radius (r_q_radius),
        .i_e_radius (e_radius),
        .o_done     (dist_done),
        .o_dn       (dn),
        .o_db       (db),
        .o_r2       (r2)
    );

    // Contact test for the selected mode.
    always_comb begin
        case (r_q_mode)
            MODE_ENTER: match = (dn <= r2) && (db > r2);
            MODE_EXIT:  match = (dn >= r2) && (db < r2);
            default:    match = dn < r2;
        endcase
    end

    // Scan sequencer and result word.
    always_comb begin
        n_state      = r_state;
        n_idx        = r_idx;
        n_pend_valid = r_pend_valid;
        n_pend_slot  = r_pend_slot;
        n_out_valid  = r_out_valid && !o_rsp.ready;
        n_out        = r_out;
        case (r_state)
            S_IDLE: begin
                if (accept && i_req.data.command == CMD_QUERY) begin
                    n_state      = S_ADDR;
                    n_idx        = '0;
                    n_pend_valid = 1'b0;
                end
            end
            S_ADDR: begin
                if (cand) begin
                    n_state = S_LOAD;
                end else if (r_idx == LAST_IDX) begin
                    n_state = S_FIN;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_LOAD: begin
                if (tag_ok) begin
                    n_state = S_CALC;
                end else if (r_idx == LAST_IDX) begin
                    n_state = S_FIN;
                end else begin
                    n_state = S_ADDR;
                    n_idx   = r_idx + 1'b1;
                end
            end
            S_CALC: begin
                if (dist_done) begin
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                if (match && r_q_mode != MODE_ALL) begin
                    // Single-hit modes end the scan on the first match.
                    if (out_free) begin
                        n_out_valid = 1'b1;
                        n_out       = '{hit: 1'b1, hit_slot: SLOT_W'(r_idx), last: 1'b1};
                        n_state     = S_IDLE;
                    end
                end else if (match && r_pend_valid && !out_free) begin
                    n_state = S_EVAL;
                end else begin
                    // In all-overlaps mode one hit is held back so that the
                    // final one can carry the last mark.
                    if (match) begin
                        if (r_pend_valid) begin
                            n_out_valid = 1'b1;
                            n_out = '{hit: 1'b1, hit_slot: SLOT_W'(r_pend_slot), last: 1'b0};
                        end
                        n_pend_valid = 1'b1;
                        n_pend_slot  = r_idx;
                    end
                    if (r_idx == LAST_IDX) begin
                        n_state = S_FIN;
                    end else begin
                        n_state = S_ADDR;
                        n_idx   = r_idx + 1'b1;
                    end
                end
            end
            S_FIN: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    if (r_pend_valid) begin
                        n_out = '{hit: 1'b1, hit_slot: SLOT_W'(r_pend_slot), last: 1'b1};
                    end else begin
                        n_out = '{hit: 1'b0, hit_slot: '0, last: 1'b1};
                    end
                    n_pend_valid = 1'b0;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_idx        <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_idx        <= n_idx;
            r_pend_valid <= n_pend_valid;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend_slot <= n_pend_slot;
        r_out       <= n_out;
    end

    assign o_rsp.valid = r_out_valid;
    assign o_rsp.data  = r_out;

    // A held-back hit only exists while a scan is running.
    `SCQE_ASSERT_SAME(a_pend_in_scan, i_clk, i_rst_n, r_pend_valid, r_state != S_IDLE)
    // The distance unit only finishes while the sequencer waits for it.
    `SCQE_ASSERT_SAME(a_done_in_calc, i_clk, i_rst_n, dist_done, r_state == S_CALC)
    // A miss word is always the final word of its query and names slot zero.
    `SCQE_ASSERT_SAME(a_miss_form, i_clk, i_rst_n, r_out_valid && !r_out.hit, r_out.last && (r_out.hit_slot == '0))
    // Starting a comparison always moves the sequencer into the wait state.
    `SCQE_ASSERT_NEXT(a_start_calc, i_clk, i_rst_n, dist_start, r_state == S_CALC)

endmodule
